// File: sv/sd_spi_sector_sequencer_core_assert.svh
// ----------------------------------------------------------------------------
// SD SPI sector sequencer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_SECTOR_SEQUENCER_CORE_ASSERT_SVH
`define SD_SPI_SECTOR_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define SSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sss_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI sector sequencer package
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int CNT_W = ($clog2(SECTOR_BYTES + 1) > 8) ? $clog2(SECTOR_BYTES + 1) : 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    typedef logic [CNT_W-1:0] cnt_t;
    localparam cnt_t SECTOR_CNT = cnt_t'(SECTOR_BYTES);
    localparam cnt_t FRAME_LEN = cnt_t'(6);

    localparam logic [7:0] CMD0_CODE  = 8'h40;
    localparam logic [7:0] CMD0_CRC   = 8'h95;
    localparam logic [7:0] CMD1_CODE  = 8'h41;
    localparam logic [7:0] WRITE_CODE = 8'h58;
    localparam logic [7:0] READ_CODE  = 8'h51;
    localparam logic [7:0] DATA_TOKEN = 8'hFE;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] R1_READY   = 8'h00;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_INIT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_IDLE_TO  = 2'd1,
        ST_READY_TO = 2'd2,
        ST_REJECT   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAKE  = 3'd0,
        REG_IDLE  = 3'd1,
        REG_READY = 3'd2,
        REG_POLLS = 3'd3,
        REG_GAP   = 3'd4
    } reg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_WAKE   = 5'd1,
        PH_LEAD   = 5'd2,
        PH_FRAME  = 5'd3,
        PH_POLL   = 5'd4,
        PH_RTOKEN = 5'd5,
        PH_RDATA  = 5'd6,
        PH_RCRC1  = 5'd7,
        PH_RCRC2  = 5'd8,
        PH_WGAP   = 5'd9,
        PH_WTOKEN = 5'd10,
        PH_WDATA  = 5'd11,
        PH_WCRC1  = 5'd12,
        PH_WCRC2  = 5'd13,
        PH_WBUSY  = 5'd14
    } phase_t;

    typedef struct packed {
        logic [7:0] wake_bytes;
        logic [7:0] idle_attempts;
        logic [7:0] ready_attempts;
        logic [9:0] response_polls;
        logic [7:0] write_gap_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] mosi;
        logic       exchange;
        logic       cs_active;
        logic       need_wdata;
        logic [7:0] rdata;
        logic       rdata_valid;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] resp;
    } res_t;

endpackage

`default_nettype wire

// File: sv/sss_cfg.sv
// ----------------------------------------------------------------------------
// SD SPI sector sequencer configuration registers
// Holds the timing and retry registers written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [sss_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [sss_pkg::CFG_DATA_W-1:0] wr_data,
    output sss_pkg::cfg_t                       cfg
);

    sss_pkg::cfg_t cfg_reg;
    sss_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                sss_pkg::REG_WAKE:  cfg_next.wake_bytes      = wr_data[7:0];
                sss_pkg::REG_IDLE:  cfg_next.idle_attempts   = wr_data[7:0];
                sss_pkg::REG_READY: cfg_next.ready_attempts  = wr_data[7:0];
                sss_pkg::REG_POLLS: cfg_next.response_polls  = wr_data[9:0];
                sss_pkg::REG_GAP:   cfg_next.write_gap_bytes = wr_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wake_bytes      <= 8'd15;
            cfg_reg.idle_attempts   <= 8'd7;
            cfg_reg.ready_attempts  <= 8'd102;
            cfg_reg.response_polls  <= 10'd502;
            cfg_reg.write_gap_bytes <= 8'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: sv/sss_seq.sv
// ----------------------------------------------------------------------------
// SD SPI sector sequencer phase engine
// Decides the next byte, select level and status for each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [1:0]    cmd,
    input  wire logic [22:0]   sector,
    input  wire logic [7:0]    miso,
    input  wire logic [7:0]    wdata,
    input  sss_pkg::cfg_t      cfg,
    output sss_pkg::res_t      res
);

    sss_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      kind_reg, kind_next;
    logic [47:0]     frame_reg, frame_next;
    sss_pkg::cnt_t   byte_reg, byte_next;
    logic [9:0]      poll_reg, poll_next;
    logic [7:0]      att_reg, att_next;
    logic            cs_reg, cs_next;
    logic [7:0]      lresp_reg, lresp_next;

    logic            req;
    logic            first;
    logic            init_ok;
    logic            resp_bad;
    logic            poll_done;
    logic [9:0]      polls_min;
    logic [7:0]      att_inc;
    logic [7:0]      att_lim;
    logic            att_fail;
    logic            gap_more;
    logic            wake_more;
    sss_pkg::cnt_t   byte_inc;
    logic [7:0]      frame_byte;

    assign req       = (cmd != sss_pkg::CMD_BYTE);
    assign first     = (frame_reg[47:40] == sss_pkg::CMD0_CODE);
    assign init_ok   = first ? (miso == sss_pkg::R1_IDLE) : (miso == sss_pkg::R1_READY);
    assign resp_bad  = (miso != sss_pkg::R1_READY);
    assign polls_min = (cfg.response_polls == 10'd0) ? 10'd1 : cfg.response_polls;
    assign poll_done = (miso != sss_pkg::FILL_BYTE) || (poll_reg >= polls_min);
    assign att_inc   = att_reg + 8'd1;
    assign att_lim   = first ? ((cfg.idle_attempts == 8'd0) ? 8'd1 : cfg.idle_attempts)
                             : ((cfg.ready_attempts == 8'd0) ? 8'd1 : cfg.ready_attempts);
    assign att_fail  = (att_inc >= att_lim);
    assign gap_more  = (byte_reg < sss_pkg::cnt_t'(cfg.write_gap_bytes));
    assign wake_more = (byte_reg < sss_pkg::cnt_t'(cfg.wake_bytes));
    assign byte_inc  = byte_reg + sss_pkg::cnt_t'(1);

    always_comb
    begin
        case (byte_reg[2:0])
            3'd0:    frame_byte = frame_reg[47:40];
            3'd1:    frame_byte = frame_reg[39:32];
            3'd2:    frame_byte = frame_reg[31:24];
            3'd3:    frame_byte = frame_reg[23:16];
            3'd4:    frame_byte = frame_reg[15:8];
            3'd5:    frame_byte = frame_reg[7:0];
            default: frame_byte = sss_pkg::FILL_BYTE;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        frame_next = frame_reg;
        byte_next  = byte_reg;
        poll_next  = poll_reg;
        att_next   = att_reg;
        cs_next    = cs_reg;
        lresp_next = lresp_reg;
        if (req)
        begin
            kind_next  = cmd;
            byte_next  = '0;
            poll_next  = '0;
            att_next   = '0;
            cs_next    = 1'b0;
            phase_next = sss_pkg::PH_LEAD;
            if (cmd == sss_pkg::CMD_INIT)
            begin
                frame_next = {sss_pkg::CMD0_CODE, 32'd0, sss_pkg::CMD0_CRC};
                if (cfg.wake_bytes != 8'd0)
                begin
                    phase_next = sss_pkg::PH_WAKE;
                    byte_next  = sss_pkg::cnt_t'(1);
                end
            end
            else
            begin
                frame_next = {(cmd == sss_pkg::CMD_READ) ? sss_pkg::READ_CODE
                                                         : sss_pkg::WRITE_CODE,
                              sector, 9'd0, sss_pkg::FILL_BYTE};
            end
        end
        else
        begin
            case (phase_reg)
                sss_pkg::PH_WAKE:
                begin
                    if (wake_more)
                    begin
                        byte_next = byte_inc;
                    end
                    else
                    begin
                        phase_next = sss_pkg::PH_LEAD;
                        cs_next    = 1'b0;
                    end
                end
                sss_pkg::PH_LEAD:
                begin
                    phase_next = sss_pkg::PH_FRAME;
                    cs_next    = 1'b1;
                    byte_next  = sss_pkg::cnt_t'(1);
                end
                sss_pkg::PH_FRAME:
                begin
                    if (byte_reg < sss_pkg::FRAME_LEN)
                    begin
                        byte_next = byte_inc;
                    end
                    else
                    begin
                        phase_next = sss_pkg::PH_POLL;
                        poll_next  = 10'd1;
                    end
                end
                sss_pkg::PH_POLL:
                begin
                    if (poll_done)
                    begin
                        lresp_next = miso;
                        case (kind_reg)
                            sss_pkg::CMD_INIT:
                            begin
                                if (init_ok)
                                begin
                                    if (first)
                                    begin
                                        att_next   = '0;
                                        frame_next = {sss_pkg::CMD1_CODE, 32'd0,
                                                      sss_pkg::FILL_BYTE};
                                        phase_next = sss_pkg::PH_LEAD;
                                        cs_next    = 1'b0;
                                    end
                                    else
                                    begin
                                        phase_next = sss_pkg::PH_IDLE;
                                        cs_next    = 1'b0;
                                    end
                                end
                                else
                                begin
                                    att_next = att_inc;
                                    if (att_fail)
                                    begin
                                        phase_next = sss_pkg::PH_IDLE;
                                        cs_next    = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = sss_pkg::PH_LEAD;
                                        cs_next    = 1'b0;
                                    end
                                end
                            end
                            sss_pkg::CMD_READ:
                            begin
                                if (resp_bad)
                                begin
                                    phase_next = sss_pkg::PH_IDLE;
                                    cs_next    = 1'b0;
                                end
                                else
                                begin
                                    phase_next = sss_pkg::PH_RTOKEN;
                                end
                            end
                            default:
                            begin
                                if (resp_bad)
                                begin
                                    phase_next = sss_pkg::PH_IDLE;
                                    cs_next    = 1'b1;
                                end
                                else if (cfg.write_gap_bytes != 8'd0)
                                begin
                                    phase_next = sss_pkg::PH_WGAP;
                                    byte_next  = sss_pkg::cnt_t'(1);
                                end
                                else
                                begin
                                    phase_next = sss_pkg::PH_WTOKEN;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        poll_next = poll_reg + 10'd1;
                    end
                end
                sss_pkg::PH_RTOKEN:
                begin
                    if (miso == sss_pkg::DATA_TOKEN)
                    begin
                        phase_next = sss_pkg::PH_RDATA;
                        byte_next  = '0;
                    end
                end
                sss_pkg::PH_RDATA:
                begin
                    byte_next = byte_inc;
                    if (byte_inc >= sss_pkg::SECTOR_CNT)
                    begin
                        phase_next = sss_pkg::PH_RCRC1;
                    end
                end
                sss_pkg::PH_RCRC1:
                begin
                    phase_next = sss_pkg::PH_RCRC2;
                end
                sss_pkg::PH_RCRC2:
                begin
                    phase_next = sss_pkg::PH_IDLE;
                    cs_next    = 1'b0;
                end
                sss_pkg::PH_WGAP:
                begin
                    if (gap_more)
                    begin
                        byte_next = byte_inc;
                    end
                    else
                    begin
                        phase_next = sss_pkg::PH_WTOKEN;
                    end
                end
                sss_pkg::PH_WTOKEN:
                begin
                    phase_next = sss_pkg::PH_WDATA;
                    byte_next  = sss_pkg::cnt_t'(1);
                end
                sss_pkg::PH_WDATA:
                begin
                    if (byte_reg < sss_pkg::SECTOR_CNT)
                    begin
                        byte_next = byte_inc;
                    end
                    else
                    begin
                        phase_next = sss_pkg::PH_WCRC1;
                    end
                end
                sss_pkg::PH_WCRC1:
                begin
                    phase_next = sss_pkg::PH_WCRC2;
                end
                sss_pkg::PH_WCRC2:
                begin
                    phase_next = sss_pkg::PH_WBUSY;
                end
                sss_pkg::PH_WBUSY:
                begin
                    if (miso == sss_pkg::FILL_BYTE)
                    begin
                        phase_next = sss_pkg::PH_IDLE;
                        cs_next    = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = sss_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        res             = '0;
        res.mosi        = sss_pkg::FILL_BYTE;
        res.cs_active   = cs_next;
        res.resp        = lresp_next;
        res.status      = sss_pkg::ST_OK;
        if (req)
        begin
            res.exchange = 1'b1;
        end
        else
        begin
            case (phase_reg)
                sss_pkg::PH_WAKE,
                sss_pkg::PH_RTOKEN,
                sss_pkg::PH_RCRC1,
                sss_pkg::PH_WCRC1,
                sss_pkg::PH_WCRC2:
                begin
                    res.exchange = 1'b1;
                end
                sss_pkg::PH_LEAD:
                begin
                    res.exchange = 1'b1;
                    res.mosi     = frame_reg[47:40];
                end
                sss_pkg::PH_FRAME:
                begin
                    res.exchange = 1'b1;
                    if (byte_reg < sss_pkg::FRAME_LEN)
                    begin
                        res.mosi = frame_byte;
                    end
                end
                sss_pkg::PH_POLL:
                begin
                    if (poll_done)
                    begin
                        case (kind_reg)
                            sss_pkg::CMD_INIT:
                            begin
                                if (init_ok)
                                begin
                                    res.exchange = first;
                                    res.done_res = !first;
                                end
                                else if (att_fail)
                                begin
                                    res.done_res = 1'b1;
                                    res.status   = first ? sss_pkg::ST_IDLE_TO
                                                         : sss_pkg::ST_READY_TO;
                                end
                                else
                                begin
                                    res.exchange = 1'b1;
                                end
                            end
                            sss_pkg::CMD_READ:
                            begin
                                if (resp_bad)
                                begin
                                    res.done_res = 1'b1;
                                    res.status   = sss_pkg::ST_REJECT;
                                end
                                else
                                begin
                                    res.exchange = 1'b1;
                                end
                            end
                            default:
                            begin
                                if (resp_bad)
                                begin
                                    res.done_res = 1'b1;
                                    res.status   = sss_pkg::ST_REJECT;
                                end
                                else
                                begin
                                    res.exchange = 1'b1;
                                    if (cfg.write_gap_bytes == 8'd0)
                                    begin
                                        res.mosi       = sss_pkg::DATA_TOKEN;
                                        res.need_wdata = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        res.exchange = 1'b1;
                    end
                end
                sss_pkg::PH_RDATA:
                begin
                    res.exchange    = 1'b1;
                    res.rdata       = miso;
                    res.rdata_valid = 1'b1;
                end
                sss_pkg::PH_RCRC2:
                begin
                    res.done_res = 1'b1;
                end
                sss_pkg::PH_WGAP:
                begin
                    res.exchange = 1'b1;
                    if (!gap_more)
                    begin
                        res.mosi       = sss_pkg::DATA_TOKEN;
                        res.need_wdata = 1'b1;
                    end
                end
                sss_pkg::PH_WTOKEN:
                begin
                    res.exchange   = 1'b1;
                    res.mosi       = wdata;
                    res.need_wdata = (sss_pkg::cnt_t'(1) < sss_pkg::SECTOR_CNT);
                end
                sss_pkg::PH_WDATA:
                begin
                    res.exchange = 1'b1;
                    if (byte_reg < sss_pkg::SECTOR_CNT)
                    begin
                        res.mosi       = wdata;
                        res.need_wdata = (byte_inc < sss_pkg::SECTOR_CNT);
                    end
                end
                sss_pkg::PH_WBUSY:
                begin
                    if (miso == sss_pkg::FILL_BYTE)
                    begin
                        res.done_res = 1'b1;
                    end
                    else
                    begin
                        res.exchange = 1'b1;
                    end
                end
                default:
                begin
                    res.exchange = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sss_pkg::PH_IDLE;
            kind_reg  <= '0;
            frame_reg <= '0;
            byte_reg  <= '0;
            poll_reg  <= '0;
            att_reg   <= '0;
            cs_reg    <= 1'b0;
            lresp_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            frame_reg <= frame_next;
            byte_reg  <= byte_next;
            poll_reg  <= poll_next;
            att_reg   <= att_next;
            cs_reg    <= cs_next;
            lresp_reg <= lresp_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/sd_spi_sector_sequencer_core.sv
// ----------------------------------------------------------------------------
// SD SPI sector sequencer core
// Byte-level SPI-mode SD/MMC host: init, sector read and sector write.
// ----------------------------------------------------------------------------
// Each input transaction reports one finished byte exchange (or starts a
// request) and yields one result transaction naming the next byte to send,
// whether to exchange it and the select level. One transaction per clock is
// sustained while out_ready is held high; a transaction passes an input
// register and then a result register, and a stalled output holds it in the
// input register. The phase engine updates all its counters on each step.
// Configuration registers are to be written only while no request is in
// flight; the core itself does not enforce it, as cfg_ready is always high.
`default_nettype none

module sd_spi_sector_sequencer_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output wire logic                           in_ready,
    input  wire logic [1:0]                     cmd,
    input  wire logic [22:0]                    sector,
    input  wire logic [7:0]                     miso,
    input  wire logic [7:0]                     wdata,
    output wire logic                           out_valid,
    input  wire logic                           out_ready,
    output wire logic [7:0]                     mosi,
    output wire logic                           exchange,
    output wire logic                           cs_active,
    output wire logic                           need_wdata,
    output wire logic [7:0]                     rdata,
    output wire logic                           rdata_valid,
    output wire logic                           done_res,
    output wire logic [1:0]                     status,
    output wire logic [7:0]                     resp,
    input  wire logic                           cfg_valid,
    output wire logic                           cfg_ready,
    input  wire logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sss_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic          in_valid_reg;
    logic [1:0]    cmd_reg;
    logic [22:0]   sector_reg;
    logic [7:0]    miso_reg;
    logic [7:0]    wdata_reg;
    logic          out_valid_reg, out_valid_next;
    sss_pkg::res_t res_reg;
    sss_pkg::res_t res_comb;
    sss_pkg::cfg_t cfg;
    logic          advance;
    logic          in_take;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    sss_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sss_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .cmd    (cmd_reg),
        .sector (sector_reg),
        .miso   (miso_reg),
        .wdata  (wdata_reg),
        .cfg    (cfg),
        .res    (res_comb)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg    <= cmd;
            sector_reg <= sector;
            miso_reg   <= miso;
            wdata_reg  <= wdata;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mosi        = res_reg.mosi;
    assign exchange    = res_reg.exchange;
    assign cs_active   = res_reg.cs_active;
    assign need_wdata  = res_reg.need_wdata;
    assign rdata       = res_reg.rdata;
    assign rdata_valid = res_reg.rdata_valid;
    assign done_res    = res_reg.done_res;
    assign status      = res_reg.status;
    assign resp        = res_reg.resp;

endmodule

`default_nettype wire

// File: sv/sss_checker.sv
// ----------------------------------------------------------------------------
// SD SPI sector sequencer port checker
// Watches the top-level ports for inconsistent result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sd_spi_sector_sequencer_core_assert.svh"

module sss_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] mosi,
    input  wire logic       exchange,
    input  wire logic       cs_active,
    input  wire logic       need_wdata,
    input  wire logic       rdata_valid,
    input  wire logic       done_res,
    input  wire logic [1:0] status
);

    `SSS_ASSERT_SAME(a_done_idle, clk, rst_n, out_valid && done_res,
        !exchange && !need_wdata && !rdata_valid && (mosi == sss_pkg::FILL_BYTE),
        "finished transaction still drives an exchange")

    `SSS_ASSERT_SAME(a_rdata_sel, clk, rst_n, out_valid && rdata_valid,
        exchange && cs_active && !done_res,
        "read data outside a selected exchange")

    `SSS_ASSERT_SAME(a_status_done, clk, rst_n, out_valid && (status != sss_pkg::ST_OK),
        done_res,
        "error status without completion")

    `SSS_ASSERT_SAME(a_wdata_sel, clk, rst_n, out_valid && need_wdata,
        exchange && cs_active,
        "write data requested without a selected exchange")

    `SSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(mosi) && $stable(done_res),
        "stalled result transaction changed")

endmodule

bind sd_spi_sector_sequencer_core sss_checker u_sss_checker (.*);

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SD SPI sector sequencer core testbench
// A card model picks each reply byte from the host's phase: command
// responses, read tokens, busy bytes and random data, with some aborts.
// Every accepted result is checked against a cycle-free model of the host.
// The test runs under the reset settings, all-zero settings, all-max
// settings and a few small random settings.
// ----------------------------------------------------------------------------

module testbench;

    typedef struct packed {
        sss_pkg::cfg_t   cfg;
        sss_pkg::phase_t ph;
        sss_pkg::cmd_t   kind;
        logic [47:0]     frame;
        sss_pkg::cnt_t   cnt;
        sss_pkg::cnt_t   polls;
        logic [7:0]      tries;
        logic            cs;
        logic [7:0]      last_r;
    } host_state_t;

    typedef struct packed {
        sss_pkg::cmd_t cmd;
        logic [22:0]   sector;
        logic [7:0]    miso;
        logic [7:0]    wdata;
    } card_item_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [1:0]                     cmd = sss_pkg::CMD_BYTE;
    logic [22:0]                    sector = '0;
    logic [7:0]                     miso = '0;
    logic [7:0]                     wdata = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [7:0]                     mosi;
    logic                           exchange;
    logic                           cs_active;
    logic                           need_wdata;
    logic [7:0]                     rdata;
    logic                           rdata_valid;
    logic                           done_res;
    logic [1:0]                     status;
    logic [7:0]                     resp;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    host_state_t   predicted;
    host_state_t   card_view;
    card_item_t    card_items[$];
    sss_pkg::res_t exchanges_due[$];
    card_item_t    next_item;
    sss_pkg::res_t model_res;
    sss_pkg::res_t want;
    int            mismatches = 0;
    int            cycle_no = 0;
    logic          calm;

    sd_spi_sector_sequencer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .sector      (sector),
        .miso        (miso),
        .wdata       (wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mosi        (mosi),
        .exchange    (exchange),
        .cs_active   (cs_active),
        .need_wdata  (need_wdata),
        .rdata       (rdata),
        .rdata_valid (rdata_valid),
        .done_res    (done_res),
        .status      (status),
        .resp        (resp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    assign calm = (cycle_no % 3000) >= 2300;

    function automatic void send(inout sss_pkg::res_t r, input logic [7:0] b,
                                 input logic ex, input logic cs);
        r.mosi      = b;
        r.exchange  = ex;
        r.cs_active = cs;
    endfunction

    function automatic void lead_in(inout host_state_t s, inout sss_pkg::res_t r);
        s.ph = sss_pkg::PH_LEAD;
        s.cs = 1'b0;
        send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
    endfunction

    function automatic void end_request(inout host_state_t s, inout sss_pkg::res_t r,
                                        input sss_pkg::status_t st, input logic cs);
        s.ph = sss_pkg::PH_IDLE;
        s.cs = cs;
        send(r, sss_pkg::FILL_BYTE, 1'b0, s.cs);
        r.done_res = 1'b1;
        r.status   = st;
    endfunction

    function automatic sss_pkg::res_t next_exchange(inout host_state_t s,
                                                    input sss_pkg::cmd_t c,
                                                    input logic [22:0] sec,
                                                    input logic [7:0] mi,
                                                    input logic [7:0] wd);
        sss_pkg::res_t r;
        int            k;
        logic          first;
        logic          ok;
        logic [7:0]    lim;
        sss_pkg::cnt_t poll_lim;
        r = '0;
        r.mosi = sss_pkg::FILL_BYTE;
        r.cs_active = s.cs;
        if (c != sss_pkg::CMD_BYTE)
        begin
            s.kind  = c;
            s.cnt   = '0;
            s.polls = '0;
            s.tries = '0;
            if (c == sss_pkg::CMD_INIT)
            begin
                s.frame = {sss_pkg::CMD0_CODE, 32'h0, sss_pkg::CMD0_CRC};
                if (s.cfg.wake_bytes != 0)
                begin
                    s.ph  = sss_pkg::PH_WAKE;
                    s.cnt = sss_pkg::cnt_t'(1);
                    s.cs  = 1'b0;
                    send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                end
                else
                    lead_in(s, r);
            end
            else
            begin
                s.frame = {(c == sss_pkg::CMD_READ) ? sss_pkg::READ_CODE
                                                    : sss_pkg::WRITE_CODE,
                           sec, 9'h0, sss_pkg::FILL_BYTE};
                lead_in(s, r);
            end
        end
        else
        begin
            case (s.ph)
                sss_pkg::PH_WAKE:
                    if (s.cnt < sss_pkg::cnt_t'(s.cfg.wake_bytes))
                    begin
                        s.cnt = s.cnt + sss_pkg::cnt_t'(1);
                        send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                    end
                    else
                        lead_in(s, r);
                sss_pkg::PH_LEAD:
                begin
                    s.ph  = sss_pkg::PH_FRAME;
                    s.cs  = 1'b1;
                    s.cnt = sss_pkg::cnt_t'(1);
                    send(r, s.frame[47:40], 1'b1, s.cs);
                end
                sss_pkg::PH_FRAME:
                    if (s.cnt < sss_pkg::FRAME_LEN)
                    begin
                        k = int'(s.cnt);
                        send(r, s.frame[8*(5-k) +: 8], 1'b1, s.cs);
                        s.cnt = s.cnt + sss_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        s.ph    = sss_pkg::PH_POLL;
                        s.polls = sss_pkg::cnt_t'(1);
                        send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                    end
                sss_pkg::PH_POLL:
                begin
                    poll_lim = (s.cfg.response_polls == 0)
                             ? sss_pkg::cnt_t'(1)
                             : sss_pkg::cnt_t'(s.cfg.response_polls);
                    if (mi == sss_pkg::FILL_BYTE && s.polls < poll_lim)
                    begin
                        s.polls = s.polls + sss_pkg::cnt_t'(1);
                        send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                    end
                    else
                    begin
                        s.last_r = mi;
                        if (s.kind == sss_pkg::CMD_INIT)
                        begin
                            first = s.frame[47:40] == sss_pkg::CMD0_CODE;
                            ok = first ? (mi == sss_pkg::R1_IDLE) : (mi == sss_pkg::R1_READY);
                            if (ok && first)
                            begin
                                s.tries = '0;
                                s.frame = {sss_pkg::CMD1_CODE, 32'h0, sss_pkg::FILL_BYTE};
                                lead_in(s, r);
                            end
                            else if (ok)
                                end_request(s, r, sss_pkg::ST_OK, 1'b0);
                            else
                            begin
                                s.tries = s.tries + 8'd1;
                                lim = first ? s.cfg.idle_attempts : s.cfg.ready_attempts;
                                if (lim == 0)
                                    lim = 8'd1;
                                if (s.tries >= lim)
                                    end_request(s, r, first ? sss_pkg::ST_IDLE_TO
                                                            : sss_pkg::ST_READY_TO, 1'b1);
                                else
                                    lead_in(s, r);
                            end
                        end
                        else if (s.kind == sss_pkg::CMD_READ)
                        begin
                            if (mi != sss_pkg::R1_READY)
                                end_request(s, r, sss_pkg::ST_REJECT, 1'b0);
                            else
                            begin
                                s.ph = sss_pkg::PH_RTOKEN;
                                send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                            end
                        end
                        else if (mi != sss_pkg::R1_READY)
                            end_request(s, r, sss_pkg::ST_REJECT, 1'b1);
                        else if (s.cfg.write_gap_bytes != 0)
                        begin
                            s.ph  = sss_pkg::PH_WGAP;
                            s.cnt = sss_pkg::cnt_t'(1);
                            send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                        end
                        else
                        begin
                            s.ph = sss_pkg::PH_WTOKEN;
                            send(r, sss_pkg::DATA_TOKEN, 1'b1, s.cs);
                            r.need_wdata = 1'b1;
                        end
                    end
                end
                sss_pkg::PH_RTOKEN:
                begin
                    if (mi == sss_pkg::DATA_TOKEN)
                    begin
                        s.ph  = sss_pkg::PH_RDATA;
                        s.cnt = '0;
                    end
                    send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                end
                sss_pkg::PH_RDATA:
                begin
                    r.rdata       = mi;
                    r.rdata_valid = 1'b1;
                    s.cnt = s.cnt + sss_pkg::cnt_t'(1);
                    if (s.cnt >= sss_pkg::SECTOR_CNT)
                        s.ph = sss_pkg::PH_RCRC1;
                    send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                end
                sss_pkg::PH_RCRC1:
                begin
                    s.ph = sss_pkg::PH_RCRC2;
                    send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                end
                sss_pkg::PH_RCRC2:
                    end_request(s, r, sss_pkg::ST_OK, 1'b0);
                sss_pkg::PH_WGAP:
                    if (s.cnt < sss_pkg::cnt_t'(s.cfg.write_gap_bytes))
                    begin
                        s.cnt = s.cnt + sss_pkg::cnt_t'(1);
                        send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                    end
                    else
                    begin
                        s.ph = sss_pkg::PH_WTOKEN;
                        send(r, sss_pkg::DATA_TOKEN, 1'b1, s.cs);
                        r.need_wdata = 1'b1;
                    end
                sss_pkg::PH_WTOKEN:
                begin
                    s.ph  = sss_pkg::PH_WDATA;
                    s.cnt = sss_pkg::cnt_t'(1);
                    send(r, wd, 1'b1, s.cs);
                    r.need_wdata = s.cnt < sss_pkg::SECTOR_CNT;
                end
                sss_pkg::PH_WDATA:
                    if (s.cnt < sss_pkg::SECTOR_CNT)
                    begin
                        s.cnt = s.cnt + sss_pkg::cnt_t'(1);
                        send(r, wd, 1'b1, s.cs);
                        r.need_wdata = s.cnt < sss_pkg::SECTOR_CNT;
                    end
                    else
                    begin
                        s.ph = sss_pkg::PH_WCRC1;
                        send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                    end
                sss_pkg::PH_WCRC1:
                begin
                    s.ph = sss_pkg::PH_WCRC2;
                    send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                end
                sss_pkg::PH_WCRC2:
                begin
                    s.ph = sss_pkg::PH_WBUSY;
                    send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                end
                sss_pkg::PH_WBUSY:
                    if (mi == sss_pkg::FILL_BYTE)
                        end_request(s, r, sss_pkg::ST_OK, 1'b0);
                    else
                        send(r, sss_pkg::FILL_BYTE, 1'b1, s.cs);
                default:
                begin
                    s.ph = sss_pkg::PH_IDLE;
                    send(r, sss_pkg::FILL_BYTE, 1'b0, s.cs);
                end
            endcase
        end
        r.resp = s.last_r;
        return r;
    endfunction

    function automatic void apply_reg(inout host_state_t s, input sss_pkg::reg_idx_t idx,
                                      input logic [sss_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            sss_pkg::REG_WAKE:  s.cfg.wake_bytes      = val[7:0];
            sss_pkg::REG_IDLE:  s.cfg.idle_attempts   = val[7:0];
            sss_pkg::REG_READY: s.cfg.ready_attempts  = val[7:0];
            sss_pkg::REG_POLLS: s.cfg.response_polls  = val[9:0];
            sss_pkg::REG_GAP:   s.cfg.write_gap_bytes = val[7:0];
            default: ;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic queue_item(input card_item_t it);
        void'(next_exchange(card_view, it.cmd, it.sector, it.miso, it.wdata));
        card_items.push_back(it);
    endtask

    // card side: reply bytes follow the host phase, aborts are mixed in
    task automatic fill_random(input int budget);
        int         counted;
        int         sel;
        logic       wind;
        logic [7:0] goal;
        card_item_t it;
        counted = 0;
        while (counted < budget || card_view.ph != sss_pkg::PH_IDLE)
        begin
            wind = counted >= budget;
            it.cmd    = sss_pkg::CMD_BYTE;
            it.sector = 23'($urandom);
            it.miso   = 8'($urandom);
            it.wdata  = 8'($urandom);
            if (card_view.ph == sss_pkg::PH_IDLE || (!wind && $urandom_range(0, 999) < 12))
            begin
                sel = $urandom_range(0, 99);
                if (card_view.ph == sss_pkg::PH_IDLE && sel < 8)
                    it.cmd = sss_pkg::CMD_BYTE;
                else if (sel < 45)
                    it.cmd = sss_pkg::CMD_INIT;
                else if (sel < 72)
                    it.cmd = sss_pkg::CMD_READ;
                else
                    it.cmd = sss_pkg::CMD_WRITE;
                sel = $urandom_range(0, 7);
                if (sel == 0)
                    it.sector = '0;
                else if (sel == 1)
                    it.sector = '1;
            end
            else
            begin
                case (card_view.ph)
                    sss_pkg::PH_POLL:
                        if (!wind && $urandom_range(0, 99) < 45)
                            it.miso = sss_pkg::FILL_BYTE;
                        else if (card_view.kind == sss_pkg::CMD_INIT)
                        begin
                            goal = (card_view.frame[47:40] == sss_pkg::CMD0_CODE)
                                 ? sss_pkg::R1_IDLE : sss_pkg::R1_READY;
                            if (wind || $urandom_range(0, 99) < 55)
                                it.miso = goal;
                        end
                        else if (wind || $urandom_range(0, 99) < 85)
                            it.miso = sss_pkg::R1_READY;
                        else
                            it.miso = 8'($urandom_range(1, 255));
                    sss_pkg::PH_RTOKEN:
                        if (wind || $urandom_range(0, 99) < 30)
                            it.miso = sss_pkg::DATA_TOKEN;
                        else if ($urandom_range(0, 1) == 0)
                            it.miso = sss_pkg::FILL_BYTE;
                    sss_pkg::PH_WBUSY:
                        if (wind || $urandom_range(0, 99) < 35)
                            it.miso = sss_pkg::FILL_BYTE;
                        else if ($urandom_range(0, 1) == 0)
                            it.miso = 8'h00;
                    default: ;
                endcase
            end
            if (!(card_view.ph == sss_pkg::PH_IDLE && it.cmd == sss_pkg::CMD_BYTE))
                counted++;
            queue_item(it);
        end
    endtask

    task automatic drain();
        while (card_items.size() != 0 || exchanges_due.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input sss_pkg::reg_idx_t idx,
                             input logic [sss_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(predicted, idx, val);
        apply_reg(card_view, idx, val);
    endtask

    task automatic set_config(input logic [9:0] wake, input logic [9:0] idle,
                              input logic [9:0] ready, input logic [9:0] polls,
                              input logic [9:0] gap);
        drain();
        write_reg(sss_pkg::REG_WAKE, wake);
        write_reg(sss_pkg::REG_IDLE, idle);
        write_reg(sss_pkg::REG_READY, ready);
        write_reg(sss_pkg::REG_POLLS, polls);
        write_reg(sss_pkg::REG_GAP, gap);
        cfg_valid <= 1'b0;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= sss_pkg::CMD_BYTE;
            sector   <= '0;
            miso     <= '0;
            wdata    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                model_res = next_exchange(predicted, sss_pkg::cmd_t'(cmd), sector, miso,
                                          wdata);
                exchanges_due.push_back(model_res);
            end
            if (!in_valid || in_ready)
            begin
                if (card_items.size() != 0 && (calm || $urandom_range(0, 99) >= 22))
                begin
                    next_item = card_items.pop_front();
                    cmd      <= next_item.cmd;
                    sector   <= next_item.sector;
                    miso     <= next_item.miso;
                    wdata    <= next_item.wdata;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (exchanges_due.size() == 0)
                begin
                    $error("result transaction with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = exchanges_due.pop_front();
                    check_field("mosi", want.mosi, mosi);
                    check_field("exchange", want.exchange, exchange);
                    check_field("cs_active", want.cs_active, cs_active);
                    check_field("need_wdata", want.need_wdata, need_wdata);
                    check_field("rdata", want.rdata, rdata);
                    check_field("rdata_valid", want.rdata_valid, rdata_valid);
                    check_field("done_res", want.done_res, done_res);
                    check_field("status", want.status, status);
                    check_field("resp", want.resp, resp);
                end
            end
            out_ready <= calm || $urandom_range(0, 99) >= 22;
        end
    end

    initial
    begin
        card_view = '0;
        card_view.cfg.wake_bytes      = 8'd15;
        card_view.cfg.idle_attempts   = 8'd7;
        card_view.cfg.ready_attempts  = 8'd102;
        card_view.cfg.response_polls  = 10'd502;
        card_view.cfg.write_gap_bytes = 8'd100;
        card_view.ph   = sss_pkg::PH_IDLE;
        card_view.kind = sss_pkg::CMD_BYTE;
        predicted = card_view;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // idle bytes, aborted read, rejected write, init cut short by a read
        queue_item('{sss_pkg::CMD_BYTE, 23'h0, 8'h00, 8'h00});
        queue_item('{sss_pkg::CMD_BYTE, 23'h7FFFFF, 8'hFF, 8'hFF});
        queue_item('{sss_pkg::CMD_READ, 23'h7FFFFF, 8'h00, 8'hFF});
        repeat (3) queue_item('{sss_pkg::CMD_BYTE, 23'h0, 8'hFF, 8'($urandom)});
        queue_item('{sss_pkg::CMD_WRITE, 23'h0, 8'hFF, 8'h00});
        repeat (7) queue_item('{sss_pkg::CMD_BYTE, 23'h0, 8'hFF, 8'($urandom)});
        queue_item('{sss_pkg::CMD_BYTE, 23'h0, 8'hFF, 8'hFF});
        queue_item('{sss_pkg::CMD_BYTE, 23'h0, 8'h05, 8'h00});
        queue_item('{sss_pkg::CMD_INIT, 23'h0, 8'h00, 8'h00});
        queue_item('{sss_pkg::CMD_READ, 23'h1, 8'hFF, 8'hFF});
        repeat (7) queue_item('{sss_pkg::CMD_BYTE, 23'h0, 8'hFF, 8'($urandom)});
        queue_item('{sss_pkg::CMD_BYTE, 23'h0, 8'h00, 8'h00});
        fill_random(80);

        set_config(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        fill_random(80);
        set_config(10'd255, 10'd255, 10'd255, 10'd1023, 10'd255);
        fill_random(80);
        repeat (3)
        begin
            set_config(10'($urandom_range(0, 4)), 10'($urandom_range(1, 3)),
                       10'($urandom_range(1, 3)), 10'($urandom_range(1, 6)),
                       10'($urandom_range(0, 5)));
            fill_random(80);
        end

        drain();
        if (mismatches == 0 && exchanges_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
